/* hdl/mlnp_pkg.sv */
package mlnp_pkg;

    // Event kinds carried in the input tuser.
    localparam logic [2:0] OP_NOTE_ON        = 3'd0;
    localparam logic [2:0] OP_NOTE_OFF       = 3'd1;
    localparam logic [2:0] OP_PITCH_WHEEL    = 3'd2;
    localparam logic [2:0] OP_ALL_NOTES_OFF  = 3'd3;
    localparam logic [2:0] OP_ALL_SOUND_OFF  = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_LEGATO_MODE   = 1'b0;
    localparam logic CFG_GLIDE_ENABLED = 1'b1;

    // Voice commands carried in the output tuser.
    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_KILL    = 2'd2,
        CMD_BEND    = 2'd3
    } cmd_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

/* hdl/mono_last_note_priority_core.sv */
// Monophonic note controller with last-note priority.
// Input events arrive on the s_axis channel: the event kind in tuser, and the note,
// velocity and pitch wheel value in tdata. Each event except an unused kind gives
// exactly one voice command beat on the m_axis channel: the command in tuser, and
// the note, velocity, retrigger and glide flags and pitch wheel value in tdata.
// The two registers (legato mode, glide enable) are written over the cfg channel,
// which is always ready; write them only while no event is in flight.
// Held notes live in a ring buffer in a single-port-read RAM of STACK_DEPTH entries.
// A note on, pitch wheel or all-off event has its command registered in the cycle
// that takes it. A note off with notes held runs a compaction pass that reads one
// stack entry per cycle through the RAM read port and writes kept entries back
// behind the read pointer, then registers its command; a note off with an empty
// stack has its command registered in the cycle that takes it.
// The block takes a new event when it is idle and its output register is empty
// or being emptied in the same cycle; while the receiver stalls, a waiting
// command holds and no further event is taken.
// Reset empties the stack, clears the last velocity and both registers, and
// drops any pending command. The RAM itself is not cleared: only entries below
// the held count are ever read.
module mono_last_note_priority_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data,
    // Event input channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // note[6:0], velocity[13:7], bend[27:14], zero
    input  logic [2:0]  s_axis_tuser,   // opcode[2:0]
    // Voice command output channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // play_note[6:0], play_velocity[13:7],
                                        // retrigger[14], glide[15], bend_out[29:16], zero
    output logic [1:0]  m_axis_tuser    // command[1:0]
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(STACK_DEPTH);

    // Ring position of an offset from the base of the stack.
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] offset);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= DEPTH_SUM)
        begin
            sum = sum - DEPTH_SUM;
        end
        return sum[AW-1:0];
    endfunction

    // Input fields.
    logic [6:0]  in_note;
    logic [6:0]  in_velocity;
    logic [13:0] in_bend;
    logic [2:0]  in_opcode;
    logic [2:0]  op_eff;
    logic        in_accept;

    assign in_note     = s_axis_tdata[6:0];
    assign in_velocity = s_axis_tdata[13:7];
    assign in_bend     = s_axis_tdata[27:14];
    assign in_opcode   = s_axis_tuser;

    // Control state.
    mlnp_pkg::state_t state_reg, state_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] count_reg, count_next;
    logic [6:0]    last_vel_reg, last_vel_next;
    logic          legato_reg, legato_next;
    logic          glide_en_reg, glide_en_next;
    logic [CW-1:0] rd_cnt_reg, rd_cnt_next;
    logic [CW-1:0] wr_cnt_reg, wr_cnt_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers.
    logic [6:0]    target_reg, target_next;
    logic [6:0]    top_reg, top_next;
    mlnp_pkg::cmd_t cmd_reg, cmd_next;
    logic [6:0]    out_note_reg, out_note_next;
    logic [6:0]    out_vel_reg, out_vel_next;
    logic          out_retrig_reg, out_retrig_next;
    logic          out_glide_reg, out_glide_next;
    logic [13:0]   out_bend_reg, out_bend_next;

    // RAM port signals.
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [6:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [6:0]    ram_rd_data;

    mlnp_ram #(
        .WIDTH(7),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Handshakes.
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == mlnp_pkg::ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // A note on with zero velocity acts as a note off.
    always_comb
    begin
        op_eff = in_opcode;
        if ((in_opcode == mlnp_pkg::OP_NOTE_ON) && (in_velocity == 7'd0))
        begin
            op_eff = mlnp_pkg::OP_NOTE_OFF;
        end
    end

    // Next state, stack access and result formation.
    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        count_next      = count_reg;
        last_vel_next   = last_vel_reg;
        legato_next     = legato_reg;
        glide_en_next   = glide_en_reg;
        rd_cnt_next     = rd_cnt_reg;
        wr_cnt_next     = wr_cnt_reg;
        rd_pend_next    = rd_pend_reg;
        out_valid_next  = out_valid_reg;
        target_next     = target_reg;
        top_next        = top_reg;
        cmd_next        = cmd_reg;
        out_note_next   = out_note_reg;
        out_vel_next    = out_vel_reg;
        out_retrig_next = out_retrig_reg;
        out_glide_next  = out_glide_reg;
        out_bend_next   = out_bend_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = ring_addr(base_reg, count_reg[AW-1:0]);
        ram_wr_data     = in_note;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = ring_addr(base_reg, rd_cnt_reg[AW-1:0]);

        // Register writes.
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mlnp_pkg::CFG_LEGATO_MODE:   legato_next   = cfg_data;
                mlnp_pkg::CFG_GLIDE_ENABLED: glide_en_next = cfg_data;
            endcase
        end

        // The receiver takes the waiting command.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            mlnp_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (op_eff)
                        mlnp_pkg::OP_NOTE_ON:
                        begin
                            ram_wr_en = 1'b1;
                            if (count_reg == DEPTH_CNT)
                            begin
                                // Full: the oldest slot takes the new note on top.
                                ram_wr_addr = base_reg;
                                base_next   = ring_addr(base_reg, AW'(1));
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            last_vel_next   = in_velocity;
                            out_valid_next  = 1'b1;
                            cmd_next        = mlnp_pkg::CMD_START;
                            out_note_next   = in_note;
                            out_vel_next    = in_velocity;
                            out_retrig_next = legato_reg ? (count_reg == '0) : 1'b1;
                            out_glide_next  = (count_reg != '0) && glide_en_reg;
                            out_bend_next   = 14'd0;
                        end
                        mlnp_pkg::OP_NOTE_OFF:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                cmd_next        = mlnp_pkg::CMD_RELEASE;
                                out_note_next   = 7'd0;
                                out_vel_next    = 7'd0;
                                out_retrig_next = 1'b0;
                                out_glide_next  = 1'b0;
                                out_bend_next   = 14'd0;
                            end
                            else
                            begin
                                target_next  = in_note;
                                rd_cnt_next  = '0;
                                wr_cnt_next  = '0;
                                rd_pend_next = 1'b0;
                                state_next   = mlnp_pkg::ST_SCAN;
                            end
                        end
                        mlnp_pkg::OP_PITCH_WHEEL:
                        begin
                            out_valid_next  = 1'b1;
                            cmd_next        = mlnp_pkg::CMD_BEND;
                            out_note_next   = 7'd0;
                            out_vel_next    = 7'd0;
                            out_retrig_next = 1'b0;
                            out_glide_next  = 1'b0;
                            out_bend_next   = in_bend;
                        end
                        mlnp_pkg::OP_ALL_NOTES_OFF:
                        begin
                            count_next      = '0;
                            out_valid_next  = 1'b1;
                            cmd_next        = mlnp_pkg::CMD_RELEASE;
                            out_note_next   = 7'd0;
                            out_vel_next    = 7'd0;
                            out_retrig_next = 1'b0;
                            out_glide_next  = 1'b0;
                            out_bend_next   = 14'd0;
                        end
                        mlnp_pkg::OP_ALL_SOUND_OFF:
                        begin
                            count_next      = '0;
                            out_valid_next  = 1'b1;
                            cmd_next        = mlnp_pkg::CMD_KILL;
                            out_note_next   = 7'd0;
                            out_vel_next    = 7'd0;
                            out_retrig_next = 1'b0;
                            out_glide_next  = 1'b0;
                            out_bend_next   = 14'd0;
                        end
                        default:
                        begin
                            // Unused kinds are dropped without a command.
                        end
                    endcase
                end
            end

            mlnp_pkg::ST_SCAN:
            begin
                // Issue the next read while entries remain.
                if (rd_cnt_reg < count_reg)
                begin
                    ram_rd_en    = 1'b1;
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end

                // Write back kept entries behind the read pointer.
                if (rd_pend_reg && (ram_rd_data != target_reg))
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = ring_addr(base_reg, wr_cnt_reg[AW-1:0]);
                    ram_wr_data = ram_rd_data;
                    wr_cnt_next = wr_cnt_reg + 1'b1;
                    top_next    = ram_rd_data;
                end

                // All entries read and processed: fold the stack and answer.
                if (!rd_pend_reg && (rd_cnt_reg == count_reg))
                begin
                    count_next     = wr_cnt_reg;
                    state_next     = mlnp_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    out_bend_next  = 14'd0;
                    out_retrig_next = 1'b0;
                    if (wr_cnt_reg == '0)
                    begin
                        cmd_next       = mlnp_pkg::CMD_RELEASE;
                        out_note_next  = 7'd0;
                        out_vel_next   = 7'd0;
                        out_glide_next = 1'b0;
                    end
                    else
                    begin
                        cmd_next       = mlnp_pkg::CMD_START;
                        out_note_next  = top_reg;
                        out_vel_next   = last_vel_reg;
                        out_glide_next = glide_en_reg;
                    end
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlnp_pkg::ST_IDLE;
            base_reg      <= '0;
            count_reg     <= '0;
            last_vel_reg  <= '0;
            legato_reg    <= 1'b0;
            glide_en_reg  <= 1'b0;
            rd_cnt_reg    <= '0;
            wr_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            count_reg     <= count_next;
            last_vel_reg  <= last_vel_next;
            legato_reg    <= legato_next;
            glide_en_reg  <= glide_en_next;
            rd_cnt_reg    <= rd_cnt_next;
            wr_cnt_reg    <= wr_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        top_reg        <= top_next;
        cmd_reg        <= cmd_next;
        out_note_reg   <= out_note_next;
        out_vel_reg    <= out_vel_next;
        out_retrig_reg <= out_retrig_next;
        out_glide_reg  <= out_glide_next;
        out_bend_reg   <= out_bend_next;
    end

    // Output beat.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = cmd_reg;
    assign m_axis_tdata  = {2'b00, out_bend_reg, out_glide_reg, out_retrig_reg,
                            out_vel_reg, out_note_reg};

endmodule

/* hdl/mlnp_ram.sv */
module mlnp_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* tb/mono_last_note_priority_core_tb.sv */
`timescale 1ns / 1ps

module mono_last_note_priority_core_tb;

    localparam int DEPTH = 16;
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

    // One voice command, field by field.
    typedef struct packed {
        mlnp_pkg::cmd_t command;
        logic [6:0]     note;
        logic [6:0]     velocity;
        logic           retrigger;
        logic           glide;
        logic [13:0]    bend;
    } voice_cmd_t;

    typedef enum {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Shadow of the note stack and the registers.
    logic [6:0]  held_stack [DEPTH];
    int          held_depth = 0;
    logic [6:0]  last_vel = '0;
    logic        legato_on = 1'b0;
    logic        glide_on = 1'b0;

    voice_cmd_t  voice_q [$];
    int          fail_count = 0;
    int          cycle_count = 0;

    // Sender and receiver pacing.
    int          burst_left = 0;
    bit          steady_sender = 1'b0;
    rx_mode_t    rx_mode = RX_ALWAYS;
    logic [7:0]  rx_pattern = 8'hff;
    logic [2:0]  rx_phase = '0;
    int          hold_left = 0;
    logic [6:0]  note_pool [6];

    mono_last_note_priority_core #(
        .STACK_DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: a long hold-off when asked, otherwise the current stall pattern.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= rx_pattern[rx_phase];
            endcase
        end
        rx_phase <= rx_phase + 3'd1;
    end

    // Works out the voice command of one event and updates the note stack.
    // Returns 0 for an event kind that the controller ignores.
    function automatic bit predict_voice(input logic [2:0] op, input logic [6:0] nt,
                                         input logic [6:0] vel, input logic [13:0] bnd,
                                         output voice_cmd_t vc);
        bit was_held;
        int kept;
        vc = '0;
        // A note on with zero velocity acts as a note off.
        if (op == mlnp_pkg::OP_NOTE_ON && vel == 7'd0)
            op = mlnp_pkg::OP_NOTE_OFF;
        case (op)
            mlnp_pkg::OP_NOTE_ON:
            begin
                was_held = (held_depth != 0);
                // A full stack drops its oldest note.
                if (held_depth >= DEPTH)
                begin
                    for (int i = 0; i < DEPTH - 1; i++)
                        held_stack[i] = held_stack[i + 1];
                    held_depth = DEPTH - 1;
                end
                held_stack[held_depth] = nt;
                held_depth++;
                last_vel = vel;
                vc.command = mlnp_pkg::CMD_START;
                vc.note = nt;
                vc.velocity = vel;
                vc.retrigger = legato_on ? !was_held : 1'b1;
                vc.glide = was_held && glide_on;
            end
            mlnp_pkg::OP_NOTE_OFF:
            begin
                // Remove every copy of the note, keeping the order of the rest.
                kept = 0;
                for (int i = 0; i < held_depth; i++)
                begin
                    if (held_stack[i] != nt)
                    begin
                        held_stack[kept] = held_stack[i];
                        kept++;
                    end
                end
                held_depth = kept;
                if (held_depth == 0)
                    vc.command = mlnp_pkg::CMD_RELEASE;
                else
                begin
                    vc.command = mlnp_pkg::CMD_START;
                    vc.note = held_stack[held_depth - 1];
                    vc.velocity = last_vel;
                    vc.glide = glide_on;
                end
            end
            mlnp_pkg::OP_PITCH_WHEEL:
            begin
                vc.command = mlnp_pkg::CMD_BEND;
                vc.bend = bnd;
            end
            mlnp_pkg::OP_ALL_NOTES_OFF:
            begin
                held_depth = 0;
                vc.command = mlnp_pkg::CMD_RELEASE;
            end
            mlnp_pkg::OP_ALL_SOUND_OFF:
            begin
                held_depth = 0;
                vc.command = mlnp_pkg::CMD_KILL;
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Watches all three channels: tracks register writes, predicts each
    // accepted event and checks each voice command beat.
    always @(posedge clk)
    begin : watch
        voice_cmd_t want;
        voice_cmd_t got;
        voice_cmd_t next_cmd;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mlnp_pkg::CFG_LEGATO_MODE)
                    legato_on = cfg_data;
                else
                    glide_on = cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.command = mlnp_pkg::cmd_t'(m_axis_tuser);
                got.note = m_axis_tdata[6:0];
                got.velocity = m_axis_tdata[13:7];
                got.retrigger = m_axis_tdata[14];
                got.glide = m_axis_tdata[15];
                got.bend = m_axis_tdata[29:16];
                if (voice_q.size() == 0)
                begin
                    $error("voice command beat with no event waiting: command %0d",
                           m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    want = voice_q.pop_front();
                    check_field("command", want.command, got.command);
                    check_field("play_note", want.note, got.note);
                    check_field("play_velocity", want.velocity, got.velocity);
                    check_field("retrigger", want.retrigger, got.retrigger);
                    check_field("glide", want.glide, got.glide);
                    check_field("bend_out", want.bend, got.bend);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_voice(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[13:7],
                                  s_axis_tdata[27:14], next_cmd))
                    voice_q = {voice_q, next_cmd};
            end
        end
    end

    // Offers one event beat and waits until it is taken. Gaps fall between bursts.
    task automatic send_event(input logic [2:0] op, input logic [6:0] nt,
                              input logic [6:0] vel, input logic [13:0] bnd);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (!steady_sender)
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 3);
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, bnd, vel, nt};
        s_axis_tuser <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stops sending and waits until every command has come, plus a settling time.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (voice_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic legato, input logic glide);
        wait_drain();
        write_reg(mlnp_pkg::CFG_LEGATO_MODE, legato);
        write_reg(mlnp_pkg::CFG_GLIDE_ENABLED, glide);
    endtask

    // One random event, mostly notes from a small pool so that note offs hit held notes.
    task automatic send_random_event(input int on_pct, output bit makes_result);
        logic [6:0]  nt;
        logic [6:0]  vel;
        logic [13:0] bnd;
        logic [2:0]  op;
        int          roll;
        nt = ($urandom_range(0, 9) < 7) ? note_pool[$urandom_range(0, 5)]
                                        : 7'($urandom_range(0, 127));
        vel = ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
        bnd = 14'($urandom_range(0, 16383));
        roll = $urandom_range(0, 99);
        if (roll < on_pct)
            op = mlnp_pkg::OP_NOTE_ON;
        else if (roll < 88)
            op = mlnp_pkg::OP_NOTE_OFF;
        else if (roll < 93)
            op = mlnp_pkg::OP_PITCH_WHEEL;
        else if (roll < 95)
            op = mlnp_pkg::OP_ALL_NOTES_OFF;
        else if (roll < 97)
            op = mlnp_pkg::OP_ALL_SOUND_OFF;
        else
            op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        makes_result = (op <= mlnp_pkg::OP_ALL_SOUND_OFF);
        send_event(op, nt, vel, bnd);
    endtask

    // Field extremes, every event kind and the corner cases, default registers first.
    task automatic test_directed_events();
        rx_mode = RX_RANDOM;
        set_mode(1'b0, 1'b0);
        send_event(mlnp_pkg::OP_NOTE_OFF, 7'd60, 7'd0, 14'd0);
        send_event(mlnp_pkg::OP_NOTE_ON, 7'd0, 7'd127, 14'd0);
        send_event(mlnp_pkg::OP_NOTE_ON, 7'd127, 7'd1, 14'd16383);
        send_event(mlnp_pkg::OP_PITCH_WHEEL, 7'd0, 7'd0, 14'd0);
        send_event(mlnp_pkg::OP_PITCH_WHEEL, 7'd127, 7'd127, 14'd16383);
        // Note off of a note that is not held returns to the top note.
        send_event(mlnp_pkg::OP_NOTE_OFF, 7'd5, 7'd0, 14'd0);
        send_event(mlnp_pkg::OP_NOTE_OFF, 7'd127, 7'd0, 14'd0);
        // Zero velocity note on releases the last held note.
        send_event(mlnp_pkg::OP_NOTE_ON, 7'd0, 7'd0, 14'd0);
        send_event(mlnp_pkg::OP_NOTE_ON, 7'd64, 7'd100, 14'd8192);
        send_event(mlnp_pkg::OP_ALL_NOTES_OFF, 7'd0, 7'd0, 14'd0);
        send_event(mlnp_pkg::OP_NOTE_ON, 7'd65, 7'd90, 14'd0);
        send_event(mlnp_pkg::OP_ALL_SOUND_OFF, 7'd0, 7'd0, 14'd0);
        send_event(OP_UNUSED_LAST, 7'd127, 7'd127, 14'd16383);
        // Legato with glide: only the first note retriggers.
        set_mode(1'b1, 1'b1);
        send_event(mlnp_pkg::OP_NOTE_ON, 7'd40, 7'd10, 14'd0);
        send_event(mlnp_pkg::OP_NOTE_ON, 7'd41, 7'd20, 14'd0);
        send_event(mlnp_pkg::OP_NOTE_OFF, 7'd41, 7'd0, 14'd0);
        send_event(mlnp_pkg::OP_ALL_SOUND_OFF, 7'd0, 7'd0, 14'd0);
    endtask

    // Pushes one note more than the stack holds; the oldest one must be gone.
    task automatic test_stack_overflow();
        set_mode(1'b0, 1'b1);
        for (int i = 0; i <= DEPTH; i++)
            send_event(mlnp_pkg::OP_NOTE_ON, 7'(10 + i), 7'(30 + i), 14'd0);
        send_event(mlnp_pkg::OP_NOTE_OFF, 7'd10, 7'd0, 14'd0);
        send_event(mlnp_pkg::OP_ALL_NOTES_OFF, 7'd0, 7'd0, 14'd0);
    endtask

    // The receiver holds off for a long stretch while events keep coming,
    // then the sender pauses until everything has drained.
    task automatic test_receiver_holdoff();
        bit counted;
        set_mode(1'b1, 1'b0);
        foreach (note_pool[i])
            note_pool[i] = 7'($urandom_range(0, 127));
        steady_sender = 1'b1;
        rx_mode = RX_ALWAYS;
        hold_left = 300;
        for (int i = 0; i < 30; i++)
            send_random_event(60, counted);
        wait_drain();
        hold_left = 200;
        for (int i = 0; i < 30; i++)
            send_random_event(60, counted);
        wait_drain();
    endtask

    // A long random run with one register setting; pacing changes every 64 events.
    task automatic test_random_phase(input logic legato, input logic glide,
                                     input int on_pct, input int count);
        int  sent;
        bit  counted;
        set_mode(legato, glide);
        foreach (note_pool[i])
            note_pool[i] = 7'($urandom_range(0, 127));
        sent = 0;
        while (sent < count)
        begin
            if (sent % 64 == 0)
            begin
                steady_sender = ($urandom_range(0, 3) == 0);
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_pattern = 8'($urandom_range(0, 255)) | 8'h01;
                if ($urandom_range(0, 3) == 0)
                    wait_drain();
            end
            send_random_event(on_pct, counted);
            if (counted)
                sent++;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_events();
        test_stack_overflow();
        test_receiver_holdoff();
        test_random_phase(1'b0, 1'b0, 55, 420);
        test_random_phase(1'b1, 1'b1, 75, 420);
        test_random_phase(1'b1, 1'b0, 55, 420);
        test_random_phase(1'b0, 1'b1, 65, 420);
        wait_drain();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mlnp_pkg.sv
hdl/mlnp_ram.sv
hdl/mono_last_note_priority_core.sv
tb/mono_last_note_priority_core_tb.sv
